// ===== rtl/core/hnsf_pkg.sv =====
// Package with the shared constants and types of the Hessian-norm size field block.
`timescale 1ns / 1ps

package hnsf_pkg;

  // Component and entry counts.
  localparam int MAX_COMPONENTS = 4;
  localparam int WEIGHT_REGS    = 4;
  localparam int COMP_CAP       = (MAX_COMPONENTS < WEIGHT_REGS) ? MAX_COMPONENTS : WEIGHT_REGS;
  localparam int ENTRY_COUNT    = 9;
  localparam int ENTRY_IDX_W    = $clog2(ENTRY_COUNT);
  localparam int ROOT_STEPS     = 32;

  // Arithmetic widths.
  localparam int ENTRY_W = 32;
  localparam int SUM_W   = 64;
  localparam int TOTAL_W = 48;
  localparam int REM_W   = 34;

  // Configuration register indexes.
  localparam logic [2:0] REG_NUM_COMPONENTS = 3'd0;
  localparam logic [2:0] REG_WEIGHT_0       = 3'd1;
  localparam logic [2:0] REG_WEIGHT_1       = 3'd2;
  localparam logic [2:0] REG_WEIGHT_2       = 3'd3;
  localparam logic [2:0] REG_WEIGHT_3       = 3'd4;
  localparam logic [2:0] REG_MIN_SIZE       = 3'd5;
  localparam logic [2:0] REG_MAX_SIZE       = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [2:0]  NUM_COMPONENTS_RESET = 3'd1;
  localparam logic [15:0] WEIGHT_RESET         = 16'd256;
  localparam logic [31:0] MIN_SIZE_RESET       = 32'd65536;
  localparam logic [31:0] MAX_SIZE_RESET       = 32'd655360;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_SQRT   = 6'b000100,
    ST_WEIGHT = 6'b001000,
    ST_ACCUM  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/hnsf_in_if.sv =====
// Input channel interface: one Hessian item with its last-vertex mark.
`timescale 1ns / 1ps

interface hnsf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] h_xx;
  logic signed [31:0] h_xy;
  logic signed [31:0] h_xz;
  logic signed [31:0] h_yx;
  logic signed [31:0] h_yy;
  logic signed [31:0] h_yz;
  logic signed [31:0] h_zx;
  logic signed [31:0] h_zy;
  logic signed [31:0] h_zz;
  logic               last_vertex;

  modport source (
    output valid, h_xx, h_xy, h_xz, h_yx, h_yy, h_yz, h_zx, h_zy, h_zz, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, h_xx, h_xy, h_xz, h_yx, h_yy, h_yz, h_zx, h_zy, h_zz, last_vertex,
    output ready
  );
endinterface

// ===== rtl/core/hnsf_out_if.sv =====
// Output channel interface: one mesh size item with its last mark.
`timescale 1ns / 1ps

interface hnsf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] size;
  logic        last;

  modport source (
    output valid, size, last,
    input  ready
  );

  modport sink (
    input  valid, size, last,
    output ready
  );
endinterface

// ===== rtl/core/hessian_norm_size_field.sv =====
// Top level of the Hessian-norm mesh size field block.
//
// The hessian channel takes one 3x3 Hessian of one solution component per
// item. The block squares the nine entries on one shared 32x32 multiplier,
// takes a bit-serial square root, weights the norm on the same multiplier and
// adds it to a saturating total. On the item of the last component of a
// vertex, one size item leaves on the result channel.
// An item holds the block through an accept step, the squares and their sum
// (one multiplier pass per entry), the square root (two bits of the sum per
// step), a weight multiply, an add and, on the last component, a finishing
// step.
// The hessian channel is not ready while an item is at work.
// A finished size waits in an output register, so the next item is accepted
// while it waits; if the receiver still stalls when the next vertex finishes,
// the block holds in its last step until the register is free.
// The cfg port writes a register at each edge with cfg_we high; it is meant
// for use while the block is idle.
// Synchronous reset restores the register defaults and clears the component
// count, the total and the output register.
`timescale 1ns / 1ps

module hessian_norm_size_field
  import hnsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  hnsf_in_if.sink     hessian,
  hnsf_out_if.source  result
);

  // Configuration registers.
  logic [2:0]  num_components;
  logic [15:0] weight [WEIGHT_REGS];
  logic [31:0] min_size;
  logic [31:0] max_size;

  // Control and work registers.
  state_t               state;
  logic [4:0]           cnt;
  logic [1:0]           count;
  logic [TOTAL_W-1:0]   total;
  logic signed [ENTRY_W-1:0] entry [ENTRY_COUNT];
  logic                 last_hold;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     prod;
  logic [REM_W-1:0]     rem;
  logic [31:0]          root;
  logic                 out_valid;
  logic [31:0]          out_size;
  logic                 out_last;

  // Shared multiplier and the datapath around it.
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [SUM_W-1:0]     mul_p;
  logic [ENTRY_IDX_W-1:0] entry_idx;
  logic [31:0]          entry_mag;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_next;
  logic [REM_W-1:0]     rem_shift;
  logic [REM_W-1:0]     trial;
  logic [REM_W:0]       rem_diff;
  logic [TOTAL_W:0]     total_add;
  logic [TOTAL_W-1:0]   total_next;
  logic [2:0]           n_eff;
  logic [2:0]           count_inc;
  logic                 total_ge_max;
  logic [31:0]          size_diff;
  logic [31:0]          size_next;
  logic                 out_free;

  assign hessian.ready = (state == ST_IDLE);
  assign result.valid  = out_valid;
  assign result.size   = out_size;
  assign result.last   = out_last;
  assign out_free      = !out_valid || result.ready;

  // Entry magnitude; the most negative value maps to 2^31 by itself.
  assign entry_idx = (cnt[ENTRY_IDX_W-1:0] == ENTRY_IDX_W'(ENTRY_COUNT)) ? '0
                   : cnt[ENTRY_IDX_W-1:0];
  assign entry_mag = entry[entry_idx][31] ? (~entry[entry_idx] + 32'd1) : entry[entry_idx];

  // Operand selection for the one multiplier.
  always_comb begin
    if (state == ST_WEIGHT) begin
      mul_a = root;
      mul_b = {16'd0, weight[count]};
    end else begin
      mul_a = entry_mag;
      mul_b = entry_mag;
    end
  end
  assign mul_p = SUM_W'(mul_a) * SUM_W'(mul_b);

  // Saturating sum of the squares.
  assign sum_add  = {1'b0, sum} + {1'b0, prod};
  assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  // One square root step: bring down two bits and try to subtract.
  assign rem_shift = {rem[REM_W-3:0], sum[SUM_W-1:SUM_W-2]};
  assign trial     = {root, 2'b01};
  assign rem_diff  = {1'b0, rem_shift} - {1'b0, trial};

  // Weighted total, saturating at its full width.
  assign total_add  = {1'b0, total} + (TOTAL_W+1)'(prod[55:8]);
  assign total_next = total_add[TOTAL_W] ? {TOTAL_W{1'b1}} : total_add[TOTAL_W-1:0];

  // Effective component count: zero acts as one, the cap bounds it.
  always_comb begin
    if (num_components == 3'd0) begin
      n_eff = 3'd1;
    end else if (num_components > 3'(COMP_CAP)) begin
      n_eff = 3'(COMP_CAP);
    end else begin
      n_eff = num_components;
    end
  end
  assign count_inc = {1'b0, count} + 3'd1;

  // Size clamp against the total.
  assign total_ge_max = (total >= {16'd0, max_size});
  assign size_diff    = max_size - total[31:0];
  assign size_next    = (total_ge_max || (size_diff < min_size)) ? min_size : size_diff;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_components <= NUM_COMPONENTS_RESET;
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        weight[i] <= WEIGHT_RESET;
      end
      min_size <= MIN_SIZE_RESET;
      max_size <= MAX_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_COMPONENTS: num_components <= cfg_data[2:0];
        REG_WEIGHT_0:       weight[0] <= cfg_data[15:0];
        REG_WEIGHT_1:       weight[1] <= cfg_data[15:0];
        REG_WEIGHT_2:       weight[2] <= cfg_data[15:0];
        REG_WEIGHT_3:       weight[3] <= cfg_data[15:0];
        REG_MIN_SIZE:       min_size <= cfg_data;
        REG_MAX_SIZE:       max_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload capture on accept.
  always_ff @(posedge clk) begin
    if (hessian.valid && hessian.ready) begin
      entry[0]  <= hessian.h_xx;
      entry[1]  <= hessian.h_xy;
      entry[2]  <= hessian.h_xz;
      entry[3]  <= hessian.h_yx;
      entry[4]  <= hessian.h_yy;
      entry[5]  <= hessian.h_yz;
      entry[6]  <= hessian.h_zx;
      entry[7]  <= hessian.h_zy;
      entry[8]  <= hessian.h_zz;
      last_hold <= hessian.last_vertex;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finishing step sets the output register itself.
      if (out_valid && result.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (hessian.valid) begin
            sum   <= '0;
            cnt   <= '0;
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          // Square of entry cnt while the previous square is summed.
          prod <= mul_p;
          if (cnt != 5'd0) begin
            sum <= sum_next;
          end
          if (cnt == 5'(ENTRY_COUNT)) begin
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
            state <= ST_SQRT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_SQRT: begin
          sum <= {sum[SUM_W-3:0], 2'b00};
          if (!rem_diff[REM_W]) begin
            rem  <= rem_diff[REM_W-1:0];
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            root <= {root[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ROOT_STEPS - 1)) begin
            state <= ST_WEIGHT;
          end
        end
        ST_WEIGHT: begin
          prod  <= mul_p;
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          total <= total_next;
          if (count_inc < n_eff) begin
            count <= count_inc[1:0];
            state <= ST_IDLE;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Wait for a free output register, then emit and clear the vertex.
          if (out_free) begin
            out_valid <= 1'b1;
            out_size  <= size_next;
            out_last  <= last_hold;
            count     <= '0;
            total     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A result appears only out of the finishing step.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result valid rose outside the finishing step");

  // An accepted item starts the squaring pass.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (hessian.valid && hessian.ready) |=> (state == ST_SQUARE && cnt == 5'd0))
    else $error("accepted item did not start the squaring pass");

  // The root remainder never exceeds twice the partial root.
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> (rem <= REM_W'({root, 1'b0})))
    else $error("square root remainder out of range");

  // Finishing with a free output emits and clears the vertex.
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && count == 2'd0 && total == '0))
    else $error("finishing step did not emit and clear");
`endif

endmodule
